### hdl/present80_block_encrypt_top_assert.svh
// Assertion macros for the PRESENT-80 encryption pipeline.
`ifndef PRESENT80_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define PRESENT80_BLOCK_ENCRYPT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRES80_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PRES80_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/pres80_pkg.sv
// Package: PRESENT-80 constants, S-box and permutation functions.
package pres80_pkg;

    localparam int ROUNDS  = 31;
    localparam int BLK_W   = 64;
    localparam int KEY_W   = 80;
    localparam int KHI_W   = 64;
    localparam int KLO_W   = 16;
    localparam int RCNT_W  = 5;

    typedef logic [BLK_W-1:0] t_block;
    typedef logic [KEY_W-1:0] t_key;
    typedef logic [RCNT_W-1:0] t_rcnt;

    // configuration register indexes
    typedef enum logic {
        CFG_KEY_UPPER = 1'b0,
        CFG_KEY_LOWER = 1'b1
    } t_cfg_idx;

    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        unique case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            4'hF: y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    function automatic t_block sub_layer(input t_block s);
        t_block r;
        for (int n = 0; n < BLK_W / 4; n++) begin
            r[4*n +: 4] = sbox(s[4*n +: 4]);
        end
        return r;
    endfunction

    // bit i moves to 16*(i mod 4) + i/4; bit 63 stays
    function automatic t_block perm_layer(input t_block s);
        t_block r;
        for (int i = 0; i < BLK_W; i++) begin
            r[(i == BLK_W - 1) ? (BLK_W - 1) : ((i * 16) % (BLK_W - 1))] = s[i];
        end
        return r;
    endfunction

endpackage

### hdl/pres80_round_cell.sv
// One PRESENT-80 round cell: round function plus key schedule step, registered.
module pres80_round_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  pres80_pkg::t_rcnt    i_round,
    input  logic                 i_valid,
    input  pres80_pkg::t_block   i_state,
    input  pres80_pkg::t_key     i_key,
    output logic                 o_valid,
    output pres80_pkg::t_block   o_state,
    output pres80_pkg::t_key     o_key
);
    import pres80_pkg::*;

    logic   r_valid;
    t_block r_state, n_state;
    t_key   r_key, n_key;
    t_key   w_rot;

    always_comb begin
        n_state = perm_layer(sub_layer(i_state ^ i_key[KEY_W-1 -: KHI_W]));
        // rotate left by 61, S-box top nibble, round count into bits 19..15
        w_rot = {i_key[18:0], i_key[KEY_W-1:19]};
        n_key = w_rot;
        n_key[KEY_W-1 -: 4] = sbox(w_rot[KEY_W-1 -: 4]);
        n_key[19:15] = w_rot[19:15] ^ i_round;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

### hdl/present80_block_encrypt_top.sv
// Top level: PRESENT-80 encryption as a chain of round cells.
// PRESENT-80 block encryption, fully unrolled. A row of 31 identical round
// cells, one per round, each registers the block and its own copy of the
// 80-bit key schedule and hands both to the next cell whenever the chain
// advances; an output register after the last cell applies the final key
// addition. A new plaintext is taken every cycle while o_stall is low, and
// its ciphertext passes through the 31 cells and then the output register.
// A stall on the output freezes the whole chain, so o_stall follows i_stall
// while the output register holds a result. The key comes from two
// write-only registers (index 0: key bits 79..16, index 1: key bits 15..0);
// it is sampled when a block enters, so change it only while no block is
// in flight.
module present80_block_encrypt_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_addr,
    input  logic [pres80_pkg::KHI_W-1:0] i_cfg_wdata,
    // plaintext channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [pres80_pkg::BLK_W-1:0] i_plaintext,
    // ciphertext channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [pres80_pkg::BLK_W-1:0] o_ciphertext
);
    import pres80_pkg::*;

    `include "present80_block_encrypt_top_assert.svh"

    // key registers
    logic [KHI_W-1:0] r_key_upper;
    logic [KLO_W-1:0] r_key_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_KEY_UPPER: r_key_upper <= i_cfg_wdata;
                CFG_KEY_LOWER: r_key_lower <= i_cfg_wdata[KLO_W-1:0];
                default: ;
            endcase
        end
    end

    // chain advance: the whole row moves unless a finished result is stuck
    logic   r_out_valid;
    t_block r_out_data;
    logic   w_adv;

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    // tap 0 is the chain input, tap k the output of cell k-1
    logic   w_valid [0:ROUNDS];
    t_block w_state [0:ROUNDS];
    t_key   w_key   [0:ROUNDS];

    assign w_valid[0] = i_valid;
    assign w_state[0] = i_plaintext;
    assign w_key[0]   = {r_key_upper, r_key_lower};

    for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
        pres80_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_round (t_rcnt'(g + 1)),
            .i_valid (w_valid[g]),
            .i_state (w_state[g]),
            .i_key   (w_key[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1]),
            .o_key   (w_key[g+1])
        );
    end

    // output register with final key addition
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_state[ROUNDS] ^ w_key[ROUNDS][KEY_W-1 -: KHI_W];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ciphertext = r_out_data;

    // a transfer in lands in the first cell
    `PRES80_ASSERT_NEXT(a_in_to_cell0, i_clk, i_rst_n, i_valid && !o_stall, w_valid[1])
    // a frozen chain keeps the last cell's block
    `PRES80_ASSERT_NEXT(a_freeze_hold, i_clk, i_rst_n, !w_adv, $stable(w_state[ROUNDS]))
    // the last cell's result reaches the output register
    `PRES80_ASSERT_NEXT(a_last_to_out, i_clk, i_rst_n, w_valid[ROUNDS] && w_adv, o_valid)
    // the chain only stalls behind a waiting result
    `PRES80_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid)

endmodule
